@@ rtl/core/erpp_pkg.sv @@
// Shared constants, register codes and helper functions of the electric ridge
// plasma pixel generator. Used by every module under rtl/core; depends on nothing.
`default_nettype none

package erpp_pkg;

	// Field widths of the streams.
	localparam int COL_W  = 12;
	localparam int FRAC_W = 16;
	localparam int QUO_W  = COL_W + FRAC_W;
	localparam int DIM_W  = 13;
	localparam int TIME_W = 32;
	localparam int ANG_W  = 48;
	localparam int CHAN_W = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_RED    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_GREEN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_BLUE   = 3'd6;

	// Register reset values.
	localparam logic [DIM_W-1:0]        RST_FRAME_WIDTH  = 13'd800;
	localparam logic [DIM_W-1:0]        RST_FRAME_HEIGHT = 13'd600;
	localparam logic signed [15:0]      RST_SCALE        = 16'sd2560;
	localparam logic signed [31:0]      RST_DIAG         = 32'sd67107840;
	localparam logic [DIM_W-1:0]        MAX_DIM          = 13'd4096;

	// Fixed-point constants.
	localparam logic [7:0]  JIT_FREQ      = 8'd150;
	localparam logic [4:0]  JIT_TIME_RATE = 5'd20;
	localparam logic [10:0] JIT_AMP       = 11'd786;
	localparam logic [16:0] T_RATE        = 17'd85197;
	localparam logic [14:0] DIAG          = 15'd26214;
	localparam logic [15:0] THRESH        = 16'd13107;
	localparam logic [15:0] GAIN          = 16'd58982;
	localparam logic [17:0] PI_Q16        = 18'd205887;
	localparam logic [7:0]  CHAN_MAX      = 8'd255;
	localparam logic [29:0] INV_TWO_PI    = 30'd683565276;
	localparam logic [17:0] DIV3_MUL      = 18'd174763;
	localparam logic [15:0] RIDGE_ONE     = 16'd32768;
	localparam logic [15:0] PAL_BIAS      = 16'd32768;

	// Sine table: one quarter turn, both ends included.
	localparam int QTR_ENTRIES = 256;
	localparam int QTR_IDX_W   = 9;
	localparam int TURN_IDX_W  = 10;

	// Pipeline depths.
	localparam int DIV_STAGES  = QUO_W;
	localparam int TRIG_STAGES = 3;
	localparam int CHAN_STAGES = 7;
	localparam int LATENCY     = DIV_STAGES + 1 + TRIG_STAGES + 4 + TRIG_STAGES + 3
		+ CHAN_STAGES;

	// Clamp a frame dimension into the range one to MAX_DIM.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0) begin
			r = 13'd1;
		end else if (d > MAX_DIM) begin
			r = MAX_DIM;
		end
		return r;
	endfunction

	// Magnitude of sine at j/1024 turn, from a degree 9 odd polynomial in Q30,
	// rounded to Q15 and clamped. Only called with constant arguments.
	function automatic logic [15:0] quarter_sine(input int j);
		longint c1, c3, c5, c7, c9;
		longint x, x2, s, r, o;
		c1 = 64'sd1686629713;
		c3 = -64'sd693598668;
		c5 = 64'sd85569306;
		c7 = -64'sd5026995;
		c9 = 64'sd172273;
		x  = longint'(j) <<< 22;
		x2 = (x * x) >>> 30;
		s  = c9;
		s  = c7 + ((s * x2) >>> 30);
		s  = c5 + ((s * x2) >>> 30);
		s  = c3 + ((s * x2) >>> 30);
		s  = c1 + ((s * x2) >>> 30);
		r  = (s * x) >>> 30;
		if (r < 0) begin
			r = 0;
		end
		o = (r + 64'sd16384) >>> 15;
		if (o > 64'sd32767) begin
			o = 64'sd32767;
		end
		return o[15:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/electric_ridge_plasma_pixel.sv @@
// Top level of the electric ridge plasma pixel generator: stream ports,
// configuration registers and the main pipeline.
// Depends on erpp_pkg, erpp_div, erpp_trig and erpp_chan.
//
// Usage: each input beat carries one pixel's column, row and the frame time;
// each output beat carries that pixel's red, green and blue bytes, in order.
// The pipeline takes one beat per clock; its depth is set mostly by the
// 28-stage divider that normalizes the column and row, followed by three
// table-based sine stages. Throughput is one pixel per cycle. When the
// receiver holds m_tready low while an output beat waits, the whole pipeline
// freezes and s_tready drops in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with an 800 by 600 frame,
// scales of 10.0 and zero phases. Registers are written through cfg_wen,
// cfg_index and cfg_data; write them only while no pixel is in flight.
`default_nettype none

module electric_ridge_plasma_pixel (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input stream, tdata: pixel_col[11:0], pixel_row[23:12], frame_time[55:24].
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [55:0]                       s_tdata,
	// Output stream, tdata: red[7:0], green[15:8], blue[23:16].
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [23:0]                            m_tdata,
	// Register write port.
	input  wire logic                              cfg_wen,
	input  wire logic [erpp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [erpp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW = erpp_pkg::COL_W;
	localparam int QW = erpp_pkg::QUO_W;
	localparam int DW = erpp_pkg::DIM_W;
	localparam int TW = erpp_pkg::TIME_W;
	localparam int AW = erpp_pkg::ANG_W;
	localparam int ND = erpp_pkg::DIV_STAGES;
	localparam int LAT = erpp_pkg::LATENCY;

	// Configuration registers.
	logic [DW-1:0]      fw_q;
	logic [DW-1:0]      fh_q;
	logic signed [15:0] scale_x_q;
	logic signed [15:0] scale_y_q;
	logic signed [15:0] ph_red_q;
	logic signed [15:0] ph_green_q;
	logic signed [15:0] ph_blue_q;
	logic signed [31:0] diag_q;

	// Control.
	logic           adv;
	logic [LAT-1:0] vld_q;

	// Pipeline payload.
	logic [TW-1:0]      t_div_s [ND];
	logic [QW-1:0]      fx_div;
	logic [QW-1:0]      fy_div;
	logic [AW-1:0]      jang_s29;
	logic [QW-1:0]      fx_s29, fx_s30, fx_s31, fx_s32, fx_s33;
	logic [QW-1:0]      fy_s29, fy_s30, fy_s31, fy_s32, fy_s33;
	logic [TW-1:0]      t_s29, t_s30, t_s31, t_s32, t_s33, t_s34, t_s35;
	logic signed [15:0] js_s32;
	logic signed [11:0] jit_s33;
	logic signed [29:0] wx_s34;
	logic signed [29:0] wy_s34;
	logic signed [30:0] wxy_s34;
	logic signed [45:0] p1_s35;
	logic signed [45:0] p2_s35;
	logic signed [62:0] p3_s35;
	logic [48:0]        pt_s35;
	logic [AW-1:0]      a1_s36, a2_s36, a3_s36;
	logic signed [15:0] s1_s39, s2_s39, s3_s39;
	logic [16:0]        rsum_s40;
	logic [15:0]        v_s41;
	logic [15:0]        e_s42;
	logic [7:0]         red, green, blue;

	logic signed [27:0] jprod;
	logic signed [55:0] p1x, p2x;
	logic signed [71:0] p3x;
	logic [15:0]        r1, r2, r3;
	logic [35:0]        vprod;
	logic [15:0]        dlev;
	logic [31:0]        eprod;

	// Register writes; frame sizes are clamped as they are stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= erpp_pkg::RST_FRAME_WIDTH;
			fh_q       <= erpp_pkg::RST_FRAME_HEIGHT;
			scale_x_q  <= erpp_pkg::RST_SCALE;
			scale_y_q  <= erpp_pkg::RST_SCALE;
			ph_red_q   <= '0;
			ph_green_q <= '0;
			ph_blue_q  <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				erpp_pkg::CFG_FRAME_WIDTH: begin
					fw_q <= erpp_pkg::clamp_dim(cfg_data[DW-1:0]);
				end
				erpp_pkg::CFG_FRAME_HEIGHT: begin
					fh_q <= erpp_pkg::clamp_dim(cfg_data[DW-1:0]);
				end
				erpp_pkg::CFG_SCALE_X:     scale_x_q  <= $signed(cfg_data);
				erpp_pkg::CFG_SCALE_Y:     scale_y_q  <= $signed(cfg_data);
				erpp_pkg::CFG_PHASE_RED:   ph_red_q   <= $signed(cfg_data);
				erpp_pkg::CFG_PHASE_GREEN: ph_green_q <= $signed(cfg_data);
				erpp_pkg::CFG_PHASE_BLUE:  ph_blue_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Diagonal frequency, follows scale_x.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_q <= erpp_pkg::RST_DIAG;
		end else begin
			diag_q <= 32'(scale_x_q) * $signed(32'(erpp_pkg::DIAG));
		end
	end

	// The whole pipeline moves when the output register is free.
	assign adv      = !vld_q[LAT-1] || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Normalization of column and row.
	erpp_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (s_tdata[CW-1:0]),
		.dvs (fw_q),
		.quo (fx_div)
	);

	erpp_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (s_tdata[2*CW-1:CW]),
		.dvs (fh_q),
		.quo (fy_div)
	);

	// Frame time rides beside the dividers.
	always_ff @(posedge clk) begin
		if (adv) begin
			t_div_s[0] <= s_tdata[2*CW+TW-1:2*CW];
			for (int k = 1; k < ND; k++) begin
				t_div_s[k] <= t_div_s[k-1];
			end
		end
	end

	// Jitter angle.
	always_ff @(posedge clk) begin
		if (adv) begin
			jang_s29 <= AW'(fx_div) * AW'(erpp_pkg::JIT_FREQ)
				+ AW'(t_div_s[ND-1]) * AW'(erpp_pkg::JIT_TIME_RATE);
			fx_s29 <= fx_div;
			fy_s29 <= fy_div;
			t_s29  <= t_div_s[ND-1];
		end
	end

	erpp_trig u_trig_jit (
		.clk     (clk),
		.en      (adv),
		.ang     (jang_s29),
		.cos_sel (1'b0),
		.val     (js_s32)
	);

	// Coordinates wait for the jitter sine.
	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s30 <= fx_s29;
			fx_s31 <= fx_s30;
			fx_s32 <= fx_s31;
			fy_s30 <= fy_s29;
			fy_s31 <= fy_s30;
			fy_s32 <= fy_s31;
			t_s30  <= t_s29;
			t_s31  <= t_s30;
			t_s32  <= t_s31;
		end
	end

	// Jitter amplitude.
	assign jprod = 28'(js_s32) * $signed(28'(erpp_pkg::JIT_AMP));

	always_ff @(posedge clk) begin
		if (adv) begin
			jit_s33 <= jprod[26:15];
			fx_s33  <= fx_s32;
			fy_s33  <= fy_s32;
			t_s33   <= t_s32;
		end
	end

	// Jittered coordinates and their sum.
	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s34  <= $signed({2'b00, fx_s33}) + 30'(jit_s33);
			wy_s34  <= $signed({2'b00, fy_s33}) + 30'(jit_s33);
			wxy_s34 <= $signed({3'b000, fx_s33}) + $signed({3'b000, fy_s33})
				+ 31'(jit_s33) + 31'(jit_s33);
			t_s34   <= t_s33;
		end
	end

	// Spatial and time products.
	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s35 <= 46'(wx_s34) * 46'(scale_x_q);
			p2_s35 <= 46'(wy_s34) * 46'(scale_y_q);
			p3_s35 <= 63'(wxy_s34) * 63'(diag_q);
			pt_s35 <= 49'(t_s34) * 49'(erpp_pkg::T_RATE);
			t_s35  <= t_s34;
		end
	end

	// Three ridge angles, kept modulo the turn word.
	assign p1x = 56'(p1_s35);
	assign p2x = 56'(p2_s35);
	assign p3x = 72'(p3_s35);

	always_ff @(posedge clk) begin
		if (adv) begin
			a1_s36 <= p1x[55:8] + AW'(t_s35);
			a2_s36 <= p2x[55:8] - AW'(pt_s35[48:16]);
			a3_s36 <= p3x[71:24] + AW'(t_s35);
		end
	end

	erpp_trig u_trig_r1 (
		.clk     (clk),
		.en      (adv),
		.ang     (a1_s36),
		.cos_sel (1'b0),
		.val     (s1_s39)
	);

	erpp_trig u_trig_r2 (
		.clk     (clk),
		.en      (adv),
		.ang     (a2_s36),
		.cos_sel (1'b0),
		.val     (s2_s39)
	);

	erpp_trig u_trig_r3 (
		.clk     (clk),
		.en      (adv),
		.ang     (a3_s36),
		.cos_sel (1'b0),
		.val     (s3_s39)
	);

	// Ridge levels are one minus the sine magnitude.
	assign r1 = erpp_pkg::RIDGE_ONE - (s1_s39[15] ? 16'(-s1_s39) : 16'(s1_s39));
	assign r2 = erpp_pkg::RIDGE_ONE - (s2_s39[15] ? 16'(-s2_s39) : 16'(s2_s39));
	assign r3 = erpp_pkg::RIDGE_ONE - (s3_s39[15] ? 16'(-s3_s39) : 16'(s3_s39));

	always_ff @(posedge clk) begin
		if (adv) begin
			rsum_s40 <= 17'(r1) + 17'(r2) + 17'(r3);
		end
	end

	// Average of three by reciprocal multiply.
	assign vprod = 36'(rsum_s40) * 36'(erpp_pkg::DIV3_MUL);

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s41 <= vprod[34:19];
		end
	end

	// Threshold and gain give the level.
	assign dlev  = (v_s41 > erpp_pkg::THRESH) ? v_s41 - erpp_pkg::THRESH : '0;
	assign eprod = 32'(dlev) * 32'(erpp_pkg::GAIN);

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s42 <= eprod[30:15];
		end
	end

	// Palette per channel.
	erpp_chan u_chan_red (
		.clk   (clk),
		.en    (adv),
		.level (e_s42),
		.phase (ph_red_q),
		.chan  (red)
	);

	erpp_chan u_chan_green (
		.clk   (clk),
		.en    (adv),
		.level (e_s42),
		.phase (ph_green_q),
		.chan  (green)
	);

	erpp_chan u_chan_blue (
		.clk   (clk),
		.en    (adv),
		.level (e_s42),
		.phase (ph_blue_q),
		.chan  (blue)
	);

	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = {blue, green, red};

endmodule

`default_nettype wire

@@ rtl/core/erpp_div.sv @@
// Pipelined restoring divider: (num << 16) / dvs, one quotient bit per stage.
// Depends on erpp_pkg for the field widths and the stage count.
`default_nettype none

module erpp_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [erpp_pkg::COL_W-1:0]    num,
	input  wire logic [erpp_pkg::DIM_W-1:0]    dvs,
	output logic      [erpp_pkg::QUO_W-1:0]    quo
);

	localparam int CW = erpp_pkg::COL_W;
	localparam int QW = erpp_pkg::QUO_W;
	localparam int NS = erpp_pkg::DIV_STAGES;

	logic [CW-1:0] rem_s [NS];
	logic [QW-1:0] quo_s [NS];
	logic [CW-1:0] num_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [CW-1:0] rem_in;
		logic [QW-1:0] quo_in;
		logic [CW-1:0] num_in;
		logic          nbit;
		logic [CW:0]   trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = num;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign num_in = num_s[k-1];
		end

		// Bits below the column are the zero fraction bits.
		if (k < CW) begin : g_colbit
			assign nbit = num_in[CW-1-k];
		end else begin : g_zerobit
			assign nbit = 1'b0;
		end

		// Trial subtract of one quotient bit.
		assign trial = {rem_in, nbit};
		assign take  = (trial >= dvs);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? CW'(trial - dvs) : trial[CW-1:0];
				quo_s[k] <= {quo_in[QW-2:0], take};
				num_s[k] <= num_in;
			end
		end
	end

	assign quo = quo_s[NS-1];

endmodule

`default_nettype wire

@@ rtl/core/erpp_trig.sv @@
// Three-stage sine or cosine of an angle in Q16 radians, wrapped to one turn.
// Depends on erpp_pkg for the turn constant and the quarter-wave table.
`default_nettype none

module erpp_trig (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic [erpp_pkg::ANG_W-1:0]      ang,
	input  wire logic                            cos_sel,
	output logic signed [15:0]                   val
);

	localparam int AW = erpp_pkg::ANG_W;
	localparam int HW = AW / 2;
	localparam int TW = erpp_pkg::TURN_IDX_W;
	localparam int QW = erpp_pkg::QTR_IDX_W;
	localparam int NQ = erpp_pkg::QTR_ENTRIES;

	logic [AW-1:0]     plo_s1;
	logic [HW-1:0]     phi_s1;
	logic              cos_s1;
	logic [TW-1:0]     idx_s2;
	logic signed [15:0] val_s3;

	logic [AW+5:0]     plo;
	logic [AW+5:0]     phi;
	logic [AW-1:0]     frac;
	logic [TW-1:0]     idx;
	logic [QW-1:0]     tidx;
	logic [15:0]       mag;
	logic [15:0]       qtab [NQ+1];

	// Quarter-wave table, folded to constants.
	for (genvar j = 0; j <= NQ; j++) begin : g_tab
		assign qtab[j] = erpp_pkg::quarter_sine(j);
	end

	// Angle times 1/(2*pi), split in two partial products.
	assign plo = (AW+6)'(ang[HW-1:0]) * (AW+6)'(erpp_pkg::INV_TWO_PI);
	assign phi = (AW+6)'(ang[AW-1:HW]) * (AW+6)'(erpp_pkg::INV_TWO_PI);

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= plo[AW-1:0];
			phi_s1 <= phi[HW-1:0];
			cos_s1 <= cos_sel;
		end
	end

	// Fraction of a turn; cosine adds a quarter turn to the index.
	assign frac = plo_s1 + {phi_s1, HW'(0)};
	assign idx  = frac[AW-1:AW-TW] + (cos_s1 ? TW'(NQ) : TW'(0));

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2 <= idx;
		end
	end

	// Quadrant folding onto the quarter table.
	assign tidx = idx_s2[TW-2] ? QW'(NQ) - QW'(idx_s2[TW-3:0]) : QW'(idx_s2[TW-3:0]);
	assign mag  = qtab[tidx];

	always_ff @(posedge clk) begin
		if (en) begin
			val_s3 <= idx_s2[TW-1] ? $signed(16'd0 - mag) : $signed(mag);
		end
	end

	assign val = val_s3;

endmodule

`default_nettype wire

@@ rtl/core/erpp_chan.sv @@
// One color channel: cosine palette of the level plus a phase, times the level.
// Depends on erpp_pkg and erpp_trig.
`default_nettype none

module erpp_chan (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [15:0]                   level,
	input  wire logic signed [15:0]            phase,
	output logic      [erpp_pkg::CHAN_W-1:0]   chan
);

	localparam int AW = erpp_pkg::ANG_W;

	logic signed [19:0] ph_s1;
	logic signed [22:0] ang_s2;
	logic [15:0]        e_s1;
	logic [15:0]        e_s2;
	logic [15:0]        e_s3;
	logic [15:0]        e_s4;
	logic [15:0]        e_s5;
	logic [31:0]        pe_s6;
	logic [7:0]         chan_s7;

	logic signed [37:0] pprod;
	logic signed [15:0] cosv;
	logic [15:0]        pal;
	logic [39:0]        vprod;
	logic [8:0]         vraw;

	// Level plus phase, phase rescaled from Q4.12 to Q15.
	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1 <= $signed({4'b0000, level}) + $signed({phase, 3'b000});
			e_s1  <= level;
		end
	end

	// Times pi, back to Q16 radians.
	assign pprod = 38'(ph_s1) * $signed(38'(erpp_pkg::PI_Q16));

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s2 <= pprod[37:15];
			e_s2   <= e_s1;
		end
	end

	erpp_trig u_trig (
		.clk     (clk),
		.en      (en),
		.ang     (AW'(ang_s2)),
		.cos_sel (1'b1),
		.val     (cosv)
	);

	// Level travels beside the cosine lookup.
	always_ff @(posedge clk) begin
		if (en) begin
			e_s3 <= e_s2;
			e_s4 <= e_s3;
			e_s5 <= e_s4;
		end
	end

	// Palette value 0.5 + 0.5*cos in Q16, times the level.
	assign pal = erpp_pkg::PAL_BIAS + 16'(cosv);

	always_ff @(posedge clk) begin
		if (en) begin
			pe_s6 <= 32'(pal) * 32'(e_s5);
		end
	end

	// Times 255, back to a byte, saturated.
	assign vprod = 40'(pe_s6) * 40'(erpp_pkg::CHAN_MAX);
	assign vraw  = vprod[39:31];

	always_ff @(posedge clk) begin
		if (en) begin
			chan_s7 <= (vraw > 9'(erpp_pkg::CHAN_MAX)) ? erpp_pkg::CHAN_MAX : vraw[7:0];
		end
	end

	assign chan = chan_s7;

endmodule

`default_nettype wire

@@ dv/erpp_checker.sv @@
// Scoreboard for the electric ridge plasma pixel generator: it watches the
// pixel and color streams and the register port, and predicts each color.
// Depends on erpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erpp_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	input  wire logic                              s_tready,
	input  wire logic [55:0]                       s_tdata,
	input  wire logic                              m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic [23:0]                       m_tdata,
	input  wire logic                              cfg_wen,
	input  wire logic [erpp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [erpp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                     fail_count,
	output int                                     colors_pending,
	output int                                     colors_seen
);

	localparam longint JITTER_FREQ = 150;
	localparam longint JITTER_TIME = 20;
	localparam longint JITTER_AMP  = 786;
	localparam longint TIME_RATE   = 85197;
	localparam longint DIAG_GAIN   = 26214;
	localparam longint LEVEL_FLOOR = 13107;
	localparam longint LEVEL_GAIN  = 58982;
	localparam longint PI_FIX      = 205887;
	localparam longint BYTE_MAX    = 255;
	localparam bit [63:0] TURNS_PER_RAD = 64'd683565276;
	localparam bit [63:0] QUARTER_TURN  = 64'd1 << 46;
	localparam bit [63:0] TURN_MASK     = (64'd1 << 48) - 64'd1;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	// Mirror of the register file.
	logic [12:0]        width_reg, height_reg;
	logic signed [15:0] sx_reg, sy_reg, ph_r, ph_g, ph_b;

	rgb_t colors_due[$];

	// Table sine at entry k of one turn, Q1.15.
	function automatic longint table_sine(input bit [9:0] k);
		longint u, x, x2, s, r, o;
		bit [1:0] q;
		u = longint'(k) << 22;
		q = u[31:30];
		x = u & 64'h3FFF_FFFF;
		if (q[0]) begin
			x = (64'sd1 << 30) - x;
		end
		x2 = (x * x) >>> 30;
		s = 172273;
		s = -64'sd5026995 + ((s * x2) >>> 30);
		s = 64'sd85569306 + ((s * x2) >>> 30);
		s = -64'sd693598668 + ((s * x2) >>> 30);
		s = 64'sd1686629713 + ((s * x2) >>> 30);
		r = (s * x) >>> 30;
		if (r < 0) begin
			r = 0;
		end
		o = (r + 16384) >>> 15;
		if (o > 32767) begin
			o = 32767;
		end
		return q[1] ? -o : o;
	endfunction

	// Sine of a Q16 angle, with an optional offset in Q48 turns.
	function automatic longint sine_of(input longint ang, input bit [63:0] offset);
		bit [63:0] ua, fr;
		ua = ang;
		fr = (ua * TURNS_PER_RAD + offset) & TURN_MASK;
		return table_sine(fr[47:38]);
	endfunction

	function automatic longint ridge_level(input longint ang);
		longint s;
		s = sine_of(ang, 64'd0);
		return 32768 - (s < 0 ? -s : s);
	endfunction

	function automatic longint clamp_divisor(input logic [12:0] d);
		if (d == 0) begin
			return 1;
		end
		if (d > 4096) begin
			return 4096;
		end
		return longint'(d);
	endfunction

	// Palette byte for level e and a Q4.12 phase.
	function automatic logic [7:0] palette_byte(input longint e, input logic signed [15:0] ph);
		longint p, ang, pal, val;
		p = e + longint'(ph) * 8;
		ang = (p * PI_FIX) >>> 15;
		pal = 32768 + sine_of(ang, QUARTER_TURN);
		val = (pal * e * 255) >>> 31;
		if (val < 0) begin
			val = 0;
		end
		if (val > BYTE_MAX) begin
			val = BYTE_MAX;
		end
		return val[7:0];
	endfunction

	function automatic rgb_t plasma_color(input logic [55:0] beat);
		longint col, row, t, fx, fy, jit, wx, wy, a1, a2, a3, v, d, e, sx, sy;
		rgb_t c;
		col = longint'(beat[11:0]);
		row = longint'(beat[23:12]);
		t = longint'(beat[55:24]);
		sx = longint'(sx_reg);
		sy = longint'(sy_reg);
		fx = (col << 16) / clamp_divisor(width_reg);
		fy = (row << 16) / clamp_divisor(height_reg);
		jit = (sine_of(fx * JITTER_FREQ + t * JITTER_TIME, 64'd0) * JITTER_AMP) >>> 15;
		wx = fx + jit;
		wy = fy + jit;
		a1 = ((wx * sx) >>> 8) + t;
		a2 = ((wy * sy) >>> 8) - ((t * TIME_RATE) >>> 16);
		a3 = (((wx + wy) * (sx * DIAG_GAIN)) >>> 24) + t;
		v = (ridge_level(a1) + ridge_level(a2) + ridge_level(a3)) / 3;
		d = v - LEVEL_FLOOR;
		if (d < 0) begin
			d = 0;
		end
		e = (d * LEVEL_GAIN) >>> 15;
		c.red = palette_byte(e, ph_r);
		c.green = palette_byte(e, ph_g);
		c.blue = palette_byte(e, ph_b);
		return c;
	endfunction

	task automatic report(input string what, input int expv, input int gotv);
		$display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, expv, gotv);
		fail_count++;
	endtask

	assign colors_pending = colors_due.size();

	// Follow register writes, queue predictions, compare color beats.
	always @(posedge clk or negedge arst_n) begin
		rgb_t want, got;
		if (!arst_n) begin
			width_reg <= erpp_pkg::RST_FRAME_WIDTH;
			height_reg <= erpp_pkg::RST_FRAME_HEIGHT;
			sx_reg <= erpp_pkg::RST_SCALE;
			sy_reg <= erpp_pkg::RST_SCALE;
			ph_r <= '0;
			ph_g <= '0;
			ph_b <= '0;
			colors_due.delete();
			fail_count = 0;
			colors_seen <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					erpp_pkg::CFG_FRAME_WIDTH: width_reg <= cfg_data[12:0];
					erpp_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data[12:0];
					erpp_pkg::CFG_SCALE_X: sx_reg <= cfg_data;
					erpp_pkg::CFG_SCALE_Y: sy_reg <= cfg_data;
					erpp_pkg::CFG_PHASE_RED: ph_r <= cfg_data;
					erpp_pkg::CFG_PHASE_GREEN: ph_g <= cfg_data;
					erpp_pkg::CFG_PHASE_BLUE: ph_b <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				colors_due.push_back(plasma_color(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				colors_seen <= colors_seen + 1;
				got = m_tdata;
				if (colors_due.size() == 0) begin
					report("unexpected color beat", 0, int'(m_tdata));
				end else begin
					want = colors_due.pop_front();
					if (got.red !== want.red) report("red", want.red, got.red);
					if (got.green !== want.green) report("green", want.green, got.green);
					if (got.blue !== want.blue) report("blue", want.blue, got.blue);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ dv/electric_ridge_plasma_pixel_tb.sv @@
// Testbench top for the electric ridge plasma pixel generator: clock, reset,
// register settings and pixel stimulus. Depends on erpp_pkg and erpp_checker.
`timescale 1ns / 1ps
`default_nettype none

module electric_ridge_plasma_pixel_tb;

	localparam logic [erpp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_wen = 1'b0;
	logic [erpp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [erpp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count, colors_pending, colors_seen;
	int pixels_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	logic [12:0] cur_width = 13'd800, cur_height = 13'd600;

	always #4 clk = ~clk;

	electric_ridge_plasma_pixel dut (.*);

	erpp_checker u_checker (.*);

	// Receiver stalls: four patterns in turn, from always ready to random and periodic stalls.
	int rx_cycle = 0;
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle >> 8) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 1);
			2: m_tready <= ($urandom_range(0, 7) != 0);
			default: m_tready <= ((rx_cycle % 7) < 3);
		endcase
	end

	// Watchdog on cycles in which no beat moves.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout with %0d colors outstanding", colors_pending);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// One pixel beat, sent in bursts with random gaps in between.
	task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
			input logic [31:0] t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0 && s_tvalid) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {t, row, col};
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	task automatic drain();
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		burst_left = 0;
		while (colors_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [erpp_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == erpp_pkg::CFG_FRAME_WIDTH) cur_width = val[12:0];
		if (idx == erpp_pkg::CFG_FRAME_HEIGHT) cur_height = val[12:0];
	endtask

	task automatic apply_setting(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] sx, input logic [15:0] sy,
			input logic [15:0] pr, input logic [15:0] pg, input logic [15:0] pb);
		drain();
		write_reg(erpp_pkg::CFG_FRAME_WIDTH, w);
		write_reg(erpp_pkg::CFG_FRAME_HEIGHT, h);
		write_reg(erpp_pkg::CFG_SCALE_X, sx);
		write_reg(erpp_pkg::CFG_SCALE_Y, sy);
		write_reg(erpp_pkg::CFG_PHASE_RED, pr);
		write_reg(erpp_pkg::CFG_PHASE_GREEN, pg);
		write_reg(erpp_pkg::CFG_PHASE_BLUE, pb);
		// An unknown index must leave every register alone.
		write_reg(CFG_UNUSED, 16'($urandom));
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// Random pixels: mostly inside the frame, some anywhere in the field range.
	task automatic random_pixels(input int n);
		logic [11:0] col, row;
		logic [31:0] t;
		int wlim, hlim;
		wlim = (cur_width == 0) ? 1 : ((cur_width > 4096) ? 4096 : cur_width);
		hlim = (cur_height == 0) ? 1 : ((cur_height > 4096) ? 4096 : cur_height);
		repeat (n) begin
			if ($urandom_range(0, 4) == 0) begin
				col = 12'($urandom);
				row = 12'($urandom);
			end else begin
				col = 12'($urandom_range(0, wlim - 1));
				row = 12'($urandom_range(0, hlim - 1));
			end
			case ($urandom_range(0, 3))
				0: t = $urandom_range(0, 32'h000F_FFFF);
				1: t = {16'($urandom_range(0, 60)), 16'($urandom)};
				default: t = $urandom;
			endcase
			send_pixel(col, row, t);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels at reset settings: field extremes and pixels past the frame.
		send_pixel(12'd0, 12'd0, 32'd0);
		send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
		send_pixel(12'd799, 12'd599, 32'h8000_0000);
		send_pixel(12'd800, 12'd600, 32'h0001_0000);
		send_pixel(12'd400, 12'd300, 32'h0000_0001);
		send_pixel(12'hAAA, 12'h555, 32'hAAAA_AAAA);
		send_pixel(12'h555, 12'hAAA, 32'h5555_5555);
		send_pixel(12'd1, 12'd1, 32'h0003_243F);
		random_pixels(200);

		// Zero divisors are taken as one; extreme scales and phases.
		apply_setting(16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000);
		send_pixel(12'd0, 12'd0, 32'd0);
		send_pixel(12'd1, 12'd1, 32'd12345);
		send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
		random_pixels(200);

		// Divisors above the limit are taken as the limit; upper data bits ignored.
		apply_setting(16'h1FFF, 16'hF000 | 16'd4097, 16'h7FFF, 16'h8000,
			16'h8000, 16'h7FFF, 16'hFFFF);
		send_pixel(12'd4095, 12'd4095, 32'd0);
		send_pixel(12'd0, 12'd4095, 32'hFFFF_FFFF);
		random_pixels(200);

		// Smallest and largest legal frames.
		apply_setting(16'd1, 16'd4096, 16'd256, 16'hFF00, 16'd4096, 16'd8192, 16'hF000);
		send_pixel(12'd0, 12'd4095, 32'h0010_0000);
		send_pixel(12'd4095, 12'd0, 32'h0010_0000);
		random_pixels(200);

		apply_setting(16'd4096, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		random_pixels(150);

		// Random settings, including frames of a few pixels.
		repeat (5) begin
			apply_setting(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
			random_pixels(160);
		end
		apply_setting(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
			16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
			16'($urandom), 16'($urandom), 16'($urandom));
		random_pixels(150);

		// Back to the reset settings for a last stretch.
		apply_setting(16'd800, 16'd600, 16'd2560, 16'd2560, 16'd0, 16'd0, 16'd0);
		random_pixels(150);

		drain();
		$display("%0d pixels sent over 12 register settings, %0d colors checked",
			pixels_sent, colors_seen);
		$display("settings covered zero, limit and oversized frames, %s",
			"extreme scales and phases");
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/erpp_pkg.sv
rtl/core/erpp_div.sv
rtl/core/erpp_trig.sv
rtl/core/erpp_chan.sv
rtl/core/electric_ridge_plasma_pixel.sv
dv/erpp_checker.sv
dv/electric_ridge_plasma_pixel_tb.sv
